FILE: hw/rtl/salc_pkg.sv
// shared types and constants for the set-associative cache statistics block
`default_nettype none
package salc_pkg;
	localparam int unsigned MaxSetsDef = 1024;
	localparam int unsigned MaxWaysDef = 8;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 4;

	localparam logic [CfgIdxW-1:0] RegBlockLog2 = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSetLog2 = 2'd1;
	localparam logic [CfgIdxW-1:0] RegWays = 2'd2;
	localparam logic [CfgIdxW-1:0] RegPolicy = 2'd3;

	typedef enum logic [1:0] {
		OP_READ = 2'd0,
		OP_WRITE = 2'd1,
		OP_FETCH = 2'd2,
		OP_FLUSH = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [31:0] address;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic wrote_back;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] read_count;
		logic [31:0] write_count;
		logic [31:0] bytes_from_memory;
		logic [31:0] bytes_to_memory;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_FLUSH_RD,
		ST_FLUSH_WR,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic lookup_rd;
		logic update_wr;
		logic flush_rd;
		logic flush_wr;
		logic flush_init;
		logic emit;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_flush;
		logic flush_last;
	} stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/salc_ctrl.sv
// controller state machine for the cache statistics block
`default_nettype none
module salc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire salc_pkg::stat_t stat,
	output logic busy,
	output salc_pkg::ctrl_t ctrl
);
	import salc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (stat.clr_last) state_d = ST_IDLE;
			ST_IDLE: if (start) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = stat.is_flush ? ST_FLUSH_RD : ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			ST_FLUSH_RD: state_d = ST_FLUSH_WR;
			ST_FLUSH_WR: state_d = stat.flush_last ? ST_DONE : ST_FLUSH_RD;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_CLEAR: ctrl.clr_wr = 1'b1;
			ST_IDLE: begin
				busy = 1'b0;
				ctrl.capture = start;
			end
			ST_LOOKUP: begin
				ctrl.lookup_rd = !stat.is_flush;
				ctrl.flush_init = stat.is_flush;
				ctrl.flush_rd = stat.is_flush;
			end
			ST_UPDATE: begin
				ctrl.update_wr = 1'b1;
				ctrl.emit = 1'b1;
			end
			ST_FLUSH_RD: ctrl.flush_rd = 1'b1;
			ST_FLUSH_WR: ctrl.flush_wr = 1'b1;
			ST_DONE: ctrl.emit = 1'b1;
			default: ctrl = '0;
		endcase
	end
endmodule
`default_nettype wire

FILE: hw/rtl/salc_dp.sv
// datapath: set memories, lookup, replacement and counters
`default_nettype none
module salc_dp #(
	parameter int unsigned MAX_SETS = salc_pkg::MaxSetsDef,
	parameter int unsigned MAX_WAYS = salc_pkg::MaxWaysDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [salc_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [salc_pkg::CfgDataW-1:0] cfg_data,
	input wire salc_pkg::in_item_t in_item,
	input wire salc_pkg::ctrl_t ctrl,
	output salc_pkg::stat_t stat,
	output logic done,
	output salc_pkg::out_item_t out_item
);
	import salc_pkg::*;

	localparam int unsigned SetW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int unsigned WayW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned RankW = WayW;
	localparam int unsigned CntW = $clog2(MAX_WAYS + 1);
	localparam int unsigned SetLog2Max = $clog2(MAX_SETS);

	// one memory row per set, all ways side by side
	typedef logic [MAX_WAYS-1:0][31:0] tag_row_t;
	typedef logic [MAX_WAYS-1:0][RankW-1:0] rank_row_t;
	typedef logic [MAX_WAYS-1:0] bit_row_t;

	tag_row_t tag_mem [MAX_SETS];
	rank_row_t rank_mem [MAX_SETS];
	bit_row_t valid_mem [MAX_SETS];
	bit_row_t dirty_mem [MAX_SETS];

	logic [3:0] bsl_q, scl_q, ways_cfg_q;
	logic policy_q;
	logic [1:0] op_q;
	logic [31:0] blk_q;
	logic [SetW-1:0] set_q, ptr_q;
	tag_row_t tag_rd_q;
	rank_row_t rank_rd_q;
	bit_row_t valid_rd_q, dirty_rd_q;
	logic [31:0] hits_q, misses_q, reads_q, writes_q, fetched_q, written_q;
	logic hit_q, wb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q <= 4'd5;
			scl_q <= 4'd6;
			ways_cfg_q <= 4'd4;
			policy_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegBlockLog2: bsl_q <= cfg_data;
				RegSetLog2: scl_q <= cfg_data;
				RegWays: ways_cfg_q <= cfg_data;
				RegPolicy: policy_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped geometry
	logic [CntW-1:0] ways_eff;
	logic [SetW-1:0] set_mask;
	always_comb begin
		if (ways_cfg_q == 4'd0) ways_eff = CntW'(1);
		else if (32'(ways_cfg_q) > MAX_WAYS) ways_eff = CntW'(MAX_WAYS);
		else ways_eff = CntW'(ways_cfg_q);
		if (32'(scl_q) >= SetLog2Max) set_mask = SetW'(MAX_SETS - 1);
		else set_mask = SetW'((33'd1 << scl_q) - 33'd1);
	end

	logic [31:0] blk_in, block_bytes;
	assign blk_in = in_item.address >> bsl_q;
	assign block_bytes = 32'd1 << bsl_q;

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			op_q <= in_item.opcode;
			blk_q <= blk_in;
			set_q <= SetW'(blk_in) & set_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ptr_q <= '0;
		else if (ctrl.clr_wr || ctrl.flush_wr) ptr_q <= ptr_q + SetW'(1);
		else if (ctrl.flush_init) ptr_q <= '0;
	end

	assign stat.clr_last = (ptr_q == SetW'(MAX_SETS - 1));
	assign stat.flush_last = (ptr_q == SetW'(MAX_SETS - 1));
	assign stat.is_flush = (op_q == OP_FLUSH);

	// lookup and replacement decisions on the registered row
	logic in_use [MAX_WAYS];
	logic found;
	logic [WayW-1:0] hit_way, victim;
	logic [RankW-1:0] top;
	always_comb begin
		found = 1'b0;
		hit_way = '0;
		victim = '0;
		top = rank_rd_q[0];
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = (CntW'(w) < ways_eff);
			if (!found && in_use[w] && valid_rd_q[w] && tag_rd_q[w] == blk_q) begin
				found = 1'b1;
				hit_way = WayW'(w);
			end
			if (w > 0 && in_use[w] && rank_rd_q[w] > top) begin
				top = rank_rd_q[w];
				victim = WayW'(w);
			end
		end
	end

	logic [WayW-1:0] sel_way;
	logic [RankW-1:0] limit;
	logic age_on;
	rank_row_t rank_new;
	tag_row_t tag_new;
	bit_row_t valid_new, dirty_new;
	logic evict_dirty;
	always_comb begin
		sel_way = found ? hit_way : victim;
		limit = found ? rank_rd_q[hit_way] : top;
		age_on = !found || policy_q;
		rank_new = rank_rd_q;
		tag_new = tag_rd_q;
		valid_new = valid_rd_q;
		dirty_new = dirty_rd_q;
		evict_dirty = !found && valid_rd_q[victim] && dirty_rd_q[victim];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (age_on && in_use[w] && rank_rd_q[w] < limit)
				rank_new[w] = rank_rd_q[w] + RankW'(1);
		end
		if (age_on) rank_new[sel_way] = '0;
		if (found) begin
			if (op_q == OP_WRITE) dirty_new[sel_way] = 1'b1;
		end else begin
			tag_new[sel_way] = blk_q;
			valid_new[sel_way] = 1'b1;
			dirty_new[sel_way] = (op_q == OP_WRITE);
		end
	end

	// flush row: dirty-and-valid lines
	bit_row_t flush_hits;
	logic [CntW-1:0] flush_n;
	always_comb begin
		flush_hits = valid_rd_q & dirty_rd_q;
		flush_n = '0;
		for (int w = 0; w < MAX_WAYS; w++) flush_n = flush_n + CntW'(flush_hits[w]);
	end

	logic [SetW-1:0] rd_addr;
	assign rd_addr = ctrl.lookup_rd ? set_q : (ctrl.flush_init ? '0 : ptr_q);

	rank_row_t rank_init;
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) rank_init[w] = RankW'(w);
	end

	always_ff @(posedge clk) begin
		if (ctrl.lookup_rd || ctrl.flush_rd) begin
			tag_rd_q <= tag_mem[rd_addr];
			rank_rd_q <= rank_mem[rd_addr];
			valid_rd_q <= valid_mem[rd_addr];
			dirty_rd_q <= dirty_mem[rd_addr];
		end
		if (ctrl.clr_wr) begin
			rank_mem[ptr_q] <= rank_init;
			valid_mem[ptr_q] <= '0;
			dirty_mem[ptr_q] <= '0;
		end else if (ctrl.update_wr) begin
			tag_mem[set_q] <= tag_new;
			rank_mem[set_q] <= rank_new;
			valid_mem[set_q] <= valid_new;
			dirty_mem[set_q] <= dirty_new;
		end else if (ctrl.flush_wr) begin
			dirty_mem[ptr_q] <= dirty_rd_q & ~flush_hits;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			misses_q <= '0;
			reads_q <= '0;
			writes_q <= '0;
			fetched_q <= '0;
			written_q <= '0;
			hit_q <= 1'b0;
			wb_q <= 1'b0;
		end else begin
			if (ctrl.flush_init) begin
				hit_q <= 1'b0;
				wb_q <= 1'b0;
			end
			if (ctrl.update_wr) begin
				hit_q <= found;
				wb_q <= evict_dirty;
				if (found) hits_q <= hits_q + 32'd1;
				else begin
					misses_q <= misses_q + 32'd1;
					fetched_q <= fetched_q + block_bytes;
				end
				if (evict_dirty) written_q <= written_q + block_bytes;
				if (op_q == OP_READ) reads_q <= reads_q + 32'd1;
				if (op_q == OP_WRITE) writes_q <= writes_q + 32'd1;
			end
			if (ctrl.flush_wr) begin
				written_q <= written_q + (32'(flush_n) << bsl_q);
				if (flush_hits != '0) wb_q <= 1'b1;
			end
		end
	end

	// strobe in the cycle after the update or flush end, counters already hold the new values
	logic done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= ctrl.emit;
	end
	assign done = done_q;

	always_comb begin
		out_item.hit = hit_q;
		out_item.wrote_back = wb_q;
		out_item.hit_count = hits_q;
		out_item.miss_count = misses_q;
		out_item.read_count = reads_q;
		out_item.write_count = writes_q;
		out_item.bytes_from_memory = fetched_q;
		out_item.bytes_to_memory = written_q;
	end
endmodule
`default_nettype wire

FILE: hw/rtl/set_assoc_cache_lru_fifo_core.sv
// top level of the set-associative cache statistics block
//  channel   | signals                          | handshake
//  access in | start, busy, in_item            | taken when start && !busy
//  result    | done, out_item                   | one cycle strobe, no stall
//  config    | cfg_we, cfg_index, cfg_data      | written when cfg_we
// an access goes from start to done strobe through a set row read, then
// row write-back with counter update, then the result register
// a flush walks every set row, a row read and then a dirty-bit clear for each
// after reset a clearing pass over all MAX_SETS rows resets valid, dirty and
// rank rows; busy stays high until it ends
// the receiver cannot stall, so done is a single-cycle strobe
`default_nettype none
module set_assoc_cache_lru_fifo_core #(
	parameter int unsigned MAX_SETS = salc_pkg::MaxSetsDef,
	parameter int unsigned MAX_WAYS = salc_pkg::MaxWaysDef
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire salc_pkg::in_item_t in_item,
	output logic done,
	output salc_pkg::out_item_t out_item,
	input wire logic cfg_we,
	input wire logic [salc_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [salc_pkg::CfgDataW-1:0] cfg_data
);
	import salc_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// sequencer: clear pass, lookup/update, flush walk
	salc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.busy(busy),
		.ctrl(ctrl)
	);

	// set rows, hit and victim logic, statistics counters
	salc_dp #(
		.MAX_SETS(MAX_SETS),
		.MAX_WAYS(MAX_WAYS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_item(in_item),
		.ctrl(ctrl),
		.stat(stat),
		.done(done),
		.out_item(out_item)
	);
endmodule
`default_nettype wire
